/* rtl/core/vfq_pkg.sv */
// vfq_pkg: types, constants and corner tables shared by the voxel face quad emitter
// depends on nothing; imported by vfq_front, vfq_back and voxel_face_quad_emitter

package vfq_pkg;

    localparam int CELL_SPAN_DEF = 16;
    localparam int COORD_W       = 4;
    localparam int CODE_W        = 8;
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int POS_W         = 6;
    localparam int IDX_W         = 16;
    localparam int JOB_DEPTH     = 4;
    localparam int OUT_DEPTH     = 2;

    localparam logic [CODE_W-1:0] GRASS_RST = 8'd1;
    localparam logic [CODE_W-1:0] STONE_RST = 8'd2;
    localparam logic [CODE_W-1:0] WATER_RST = 8'd3;
    localparam logic [CODE_W-1:0] SAND_RST  = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRASS = 2'd0,
        CFG_STONE = 2'd1,
        CFG_WATER = 2'd2,
        CFG_SAND  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // one classified cell, waiting for the back end
    typedef struct packed {
        logic                     new_mesh;
        logic                     own_solid;
        logic [2:0]               mask;
        logic [COORD_W-1:0]       cx;
        logic [COORD_W-1:0]       cy;
        logic [COORD_W-1:0]       cz;
        logic [2:0][1:0]          col;
        logic [2:0]               row;
    } job_t;

    // one emitted vertex
    typedef struct packed {
        logic [POS_W-1:0] vx;
        logic [POS_W-1:0] vy;
        logic [POS_W-1:0] vz;
        logic [2:0]       tex_u;
        logic [1:0]       tex_v;
        logic [IDX_W-1:0] vidx;
        logic [1:0]       slot;
        logic [1:0]       axis;
        logic             last;
    } vert_t;

    // corner offset signs per coordinate (bit 0 x, bit 1 y, bit 2 z), 1 means +1
    function automatic logic [2:0] corner_plus(input logic [1:0] axis, input logic [1:0] corner);
        logic [2:0] r;
        r = 3'b111;
        unique case (axis)
            AXIS_X:
            begin
                case (corner)
                    2'd0: r = 3'b111;
                    2'd1: r = 3'b101;
                    2'd2: r = 3'b001;
                    default: r = 3'b011;
                endcase
            end
            AXIS_Y:
            begin
                case (corner)
                    2'd0: r = 3'b010;
                    2'd1: r = 3'b110;
                    2'd2: r = 3'b111;
                    default: r = 3'b011;
                endcase
            end
            default:
            begin
                case (corner)
                    2'd0: r = 3'b110;
                    2'd1: r = 3'b100;
                    2'd2: r = 3'b101;
                    default: r = 3'b111;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/voxel_face_quad_emitter.sv */
// voxel_face_quad_emitter: top level of the voxel face quad emitter
// depends on vfq_pkg, vfq_front, vfq_fifo and vfq_back
// path: a cell's first vertex passes the job queue, the work register and the output queue
// throughput: one vertex per cycle while the output queue has room; a cell with n faces yields
// 4*n vertices via the one sequencer; faceless cells cost nothing unless they restart numbering
// reset: clears both queues and the vertex counter, tile codes return to 1,2,3,4

module voxel_face_quad_emitter #(
    parameter int CELL_SPAN = vfq_pkg::CELL_SPAN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [vfq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vfq_pkg::CFG_W-1:0]           cfg_data,
    // cell input queue side
    input  logic                                push,
    output logic                                full,
    input  logic                                new_mesh,
    input  logic [vfq_pkg::COORD_W-1:0]         cell_x,
    input  logic [vfq_pkg::COORD_W-1:0]         cell_y,
    input  logic [vfq_pkg::COORD_W-1:0]         cell_z,
    input  logic [vfq_pkg::CODE_W-1:0]          own_block,
    input  logic [vfq_pkg::CODE_W-1:0]          plus_x_block,
    input  logic [vfq_pkg::CODE_W-1:0]          plus_y_block,
    input  logic [vfq_pkg::CODE_W-1:0]          plus_z_block,
    // vertex output queue side
    input  logic                                pop,
    output logic                                empty,
    output logic signed [vfq_pkg::POS_W-1:0]    vert_x,
    output logic signed [vfq_pkg::POS_W-1:0]    vert_y,
    output logic signed [vfq_pkg::POS_W-1:0]    vert_z,
    output logic [2:0]                          tex_u,
    output logic [1:0]                          tex_v,
    output logic [vfq_pkg::IDX_W-1:0]           vertex_index,
    output logic [1:0]                          corner_slot,
    output logic [1:0]                          face_axis,
    output logic                                last
);
    import vfq_pkg::*;

    job_t  fjob;
    logic  fkeep;
    logic  jf_full;
    logic  jf_empty;
    logic  jf_pop;
    logic  in_xfer;
    job_t  head;
    vert_t vert;

    // front: tile codes live here, each cell is classified in the cycle of its transfer
    vfq_front #(
        .CELL_SPAN (CELL_SPAN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .new_mesh     (new_mesh),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .own_block    (own_block),
        .plus_x_block (plus_x_block),
        .plus_y_block (plus_y_block),
        .plus_z_block (plus_z_block),
        .job          (fjob),
        .job_keep     (fkeep)
    );

    // input transfer; cells with no faces and no restart are dropped here
    assign full    = jf_full;
    assign in_xfer = push && !jf_full;

    // job queue decouples classification from vertex sequencing
    vfq_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_xfer && fkeep),
        .wr_data (fjob),
        .rd_en   (jf_pop),
        .rd_data (head),
        .full    (jf_full),
        .empty   (jf_empty)
    );

    // back: walks faces x, y, z, four corners each; one vertex per cycle unless out queue full
    vfq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .jf_empty (jf_empty),
        .jf_pop   (jf_pop),
        .pop      (pop),
        .empty    (empty),
        .vert     (vert)
    );

    // unpack the oldest waiting vertex onto the result ports
    assign vert_x       = signed'(vert.vx);
    assign vert_y       = signed'(vert.vy);
    assign vert_z       = signed'(vert.vz);
    assign tex_u        = vert.tex_u;
    assign tex_v        = vert.tex_v;
    assign vertex_index = vert.vidx;
    assign corner_slot  = vert.slot;
    assign face_axis    = vert.axis;
    assign last         = vert.last;

endmodule

/* rtl/core/vfq_fifo.sv */
// vfq_fifo: small flop-based first-in first-out queue, power-of-two depth
// depends on nothing; used for the job queue and the vertex output queue

module vfq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* rtl/core/vfq_front.sv */
// vfq_front: tile code registers, face classification and tile lookup of one cell
// depends on vfq_pkg

module vfq_front #(
    parameter int CELL_SPAN = vfq_pkg::CELL_SPAN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vfq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vfq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          new_mesh,
    input  logic [vfq_pkg::COORD_W-1:0]   cell_x,
    input  logic [vfq_pkg::COORD_W-1:0]   cell_y,
    input  logic [vfq_pkg::COORD_W-1:0]   cell_z,
    input  logic [vfq_pkg::CODE_W-1:0]    own_block,
    input  logic [vfq_pkg::CODE_W-1:0]    plus_x_block,
    input  logic [vfq_pkg::CODE_W-1:0]    plus_y_block,
    input  logic [vfq_pkg::CODE_W-1:0]    plus_z_block,
    output vfq_pkg::job_t                 job,
    output logic                          job_keep
);
    import vfq_pkg::*;

    localparam int NCOORD = 1 << COORD_W;

    logic [CODE_W-1:0]  grass_reg;
    logic [CODE_W-1:0]  stone_reg;
    logic [CODE_W-1:0]  water_reg;
    logic [CODE_W-1:0]  sand_reg;
    logic [COORD_W-1:0] mod_lut [NCOORD];
    logic [CODE_W-1:0]  nb [3];
    logic               own_solid;

    // coordinate reduction modulo the span, folded at elaboration
    for (genvar i = 0; i < NCOORD; i++)
    begin : g_mod
        localparam int MV = i % CELL_SPAN;
        assign mod_lut[i] = COORD_W'(MV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grass_reg <= GRASS_RST;
            stone_reg <= STONE_RST;
            water_reg <= WATER_RST;
            sand_reg  <= SAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRASS: grass_reg <= cfg_data;
                CFG_STONE: stone_reg <= cfg_data;
                CFG_WATER: water_reg <= cfg_data;
                CFG_SAND:  sand_reg  <= cfg_data;
                default:   grass_reg <= grass_reg;
            endcase
        end
    end

    assign nb[0]     = plus_x_block;
    assign nb[1]     = plus_y_block;
    assign nb[2]     = plus_z_block;
    assign own_solid = (own_block != '0);

    always_comb
    begin
        logic [CODE_W-1:0] code;
        job           = '0;
        job.new_mesh  = new_mesh;
        job.own_solid = own_solid;
        job.cx        = mod_lut[cell_x];
        job.cy        = mod_lut[cell_y];
        job.cz        = mod_lut[cell_z];
        for (int a = 0; a < 3; a++)
        begin
            job.mask[a] = own_solid != (nb[a] != '0);
            code        = own_solid ? own_block : nb[a];
            // first match wins; anything else falls to column 1, row 1
            if (code == grass_reg)
            begin
                job.col[a] = 2'd0;
                job.row[a] = 1'b0;
            end
            else if (code == stone_reg)
            begin
                job.col[a] = 2'd1;
                job.row[a] = 1'b0;
            end
            else if (code == water_reg)
            begin
                job.col[a] = 2'd2;
                job.row[a] = 1'b0;
            end
            else if (code == sand_reg)
            begin
                job.col[a] = 2'd3;
                job.row[a] = 1'b0;
            end
            else
            begin
                job.col[a] = 2'd1;
                job.row[a] = 1'b1;
            end
        end
    end

    // a cell without faces only matters when it restarts numbering
    assign job_keep = (job.mask != 3'b000) || new_mesh;

endmodule

/* rtl/core/vfq_back.sv */
// vfq_back: quad sequencer, vertex counter and vertex output queue
// depends on vfq_pkg and vfq_fifo

module vfq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  vfq_pkg::job_t head,
    input  logic          jf_empty,
    output logic          jf_pop,
    input  logic          pop,
    output logic          empty,
    output vfq_pkg::vert_t vert
);
    import vfq_pkg::*;

    job_t             work_reg;
    job_t             work_next;
    logic             work_valid_reg;
    logic             work_valid_next;
    logic [2:0]       mask_reg;
    logic [2:0]       mask_next;
    logic [1:0]       k_reg;
    logic [1:0]       k_next;
    logic [IDX_W-1:0] counter_reg;
    logic [IDX_W-1:0] counter_next;

    logic       of_full;
    logic       emit;
    logic       job_done;
    logic       load;
    logic [1:0] cur_axis;
    logic [2:0] rest_mask;
    logic [1:0] corner;
    logic [2:0] plus;
    logic [1:0] col;
    logic       row;
    logic       dv;
    vert_t      vout;

    always_comb
    begin
        if (mask_reg[0])
            cur_axis = AXIS_X;
        else if (mask_reg[1])
            cur_axis = AXIS_Y;
        else
            cur_axis = AXIS_Z;
    end

    always_comb
    begin
        rest_mask           = mask_reg;
        rest_mask[cur_axis] = 1'b0;
    end

    assign emit     = work_valid_reg && !of_full;
    assign job_done = emit && (k_reg == 2'd3) && (rest_mask == 3'b000);
    assign load     = (!work_valid_reg || job_done) && !jf_empty;
    assign jf_pop   = load;

    // empty cells wind the other way: corners 0,3,2,1
    assign corner = work_reg.own_solid ? k_reg : 2'(~k_reg + 2'd1);
    assign plus   = corner_plus(cur_axis, corner);
    assign col    = work_reg.col[cur_axis];
    assign row    = work_reg.row[cur_axis];
    assign dv     = ~(k_reg[0] ^ k_reg[1]);

    always_comb
    begin
        vout.vx    = {1'b0, work_reg.cx, 1'b0} + (plus[0] ? 6'd1 : 6'h3F);
        vout.vy    = {1'b0, work_reg.cy, 1'b0} + (plus[1] ? 6'd1 : 6'h3F);
        vout.vz    = {1'b0, work_reg.cz, 1'b0} + (plus[2] ? 6'd1 : 6'h3F);
        vout.tex_u = {1'b0, col} + {2'b00, k_reg[1]};
        vout.tex_v = {1'b0, row} + {1'b0, dv};
        vout.vidx  = counter_reg;
        vout.slot  = k_reg;
        vout.axis  = cur_axis;
        vout.last  = (k_reg == 2'd3) && (rest_mask == 3'b000);
    end

    always_comb
    begin
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        mask_next       = mask_reg;
        k_next          = k_reg;
        counter_next    = counter_reg;
        if (emit)
        begin
            counter_next = counter_reg + IDX_W'(1);
            k_next       = k_reg + 2'd1;
            if (k_reg == 2'd3)
                mask_next = rest_mask;
        end
        if (load)
        begin
            work_next       = head;
            mask_next       = head.mask;
            k_next          = 2'd0;
            work_valid_next = (head.mask != 3'b000);
            if (head.new_mesh)
                counter_next = '0;
        end
        else if (job_done)
        begin
            work_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            mask_reg       <= '0;
            k_reg          <= '0;
            counter_reg    <= '0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            mask_reg       <= mask_next;
            k_reg          <= k_next;
            counter_reg    <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    vfq_fifo #(
        .WIDTH ($bits(vert_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (emit),
        .wr_data (vout),
        .rd_en   (pop),
        .rd_data (vert),
        .full    (of_full),
        .empty   (empty)
    );

    a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (mask_reg != 3'b000))
        else $error("active job with no faces left");

    a_k_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 2'd0) |-> work_valid_reg)
        else $error("corner step mid-quad without an active job");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !(load && head.new_mesh)) |=> (counter_reg == $past(counter_reg) + IDX_W'(1)))
        else $error("vertex counter skipped on a transfer");

endmodule
